>>> src/color_wall_lane_offset_core_macros.svh
// Assertion macros for the red/green wall counter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef COLOR_WALL_LANE_OFFSET_CORE_MACROS_SVH
`define COLOR_WALL_LANE_OFFSET_CORE_MACROS_SVH

// Plain clocked property with reset disable.
`define CWLO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define CWLO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/cwlo_pkg.sv
// Shared types and constants of the red/green wall counter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package cwlo_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIMENSION);   // position width
  localparam int unsigned REG_W   = 13;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIRST  = 2'd2;
  localparam logic [1:0] REG_END    = 2'd3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [CNT_W-1:0]        red_count;
    logic [CNT_W-1:0]        green_count;
    logic signed [OFS_W-1:0] wall_offset;
  } result_t;

  // One classified pixel as handed from the front to the back.
  typedef struct packed {
    logic clr;
    logic red_hit;
    logic green_hit;
    logic last;
  } event_t;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
    logic [REG_W-1:0] first_row;
    logic [REG_W-1:0] end_row;
  } cfg_t;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    r = v;
    if (v < REG_W'(2)) r = REG_W'(2);
    else if (v > REG_W'(MAX_DIMENSION)) r = REG_W'(MAX_DIMENSION);
    return r;
  endfunction

endpackage

>>> src/cwlo_front.sv
// Front part: pixel position tracking and two-stage HSV classification.
// Depends on cwlo_pkg; pushes one event per pixel into the queue.
`timescale 1ns / 1ps
module cwlo_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwlo_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cwlo_pkg::pixel_t  in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cwlo_pkg::event_t  q_data_o
);

  // Reciprocal tables, rounded, with zero for a zero argument.
  logic [19:0] sdiv_tab [256];
  logic [17:0] hdiv_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam int unsigned SD = (i == 0) ? 0 : (2 * 1044480 + i) / (2 * ((i == 0) ? 1 : i));
    localparam int unsigned HD = (i == 0) ? 0 : (2 * 122880 + i) / (2 * ((i == 0) ? 1 : i));
    assign sdiv_tab[i] = 20'(SD);
    assign hdiv_tab[i] = 18'(HD);
  end

  logic [cwlo_pkg::DIM_W-1:0] col_q, col_d, row_q, row_d, col_c, row_c;
  logic [cwlo_pkg::REG_W-1:0] w, h;
  logic                       en, acc;
  logic [7:0]                 v, m, d;
  logic signed [11:0]         num;
  logic                       in_band, left, last_col, last_row;

  // Stage 1 registers
  logic               s1_v_q;
  logic [7:0]         s1_v_val_q, s1_d_q;
  logic signed [11:0] s1_num_q;
  logic [19:0]        s1_sdiv_q;
  logic [17:0]        s1_hdiv_q;
  logic               s1_rpos_q, s1_gpos_q, s1_last_q, s1_clr_q;
  // Stage 2 registers
  logic               s2_v_q;
  cwlo_pkg::event_t   s2_ev_q, s2_ev_d;

  logic [27:0]        sat_p;
  logic [15:0]        sat;
  logic signed [29:0] hue_t;
  logic signed [17:0] hue_raw, hue;
  logic               is_red, is_green;

  assign en         = !(s2_v_q && q_full_i);
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;
  assign q_push_o   = s2_v_q && !q_full_i;
  assign q_data_o   = s2_ev_q;

  always_comb begin
    w = cwlo_pkg::clamp_dim(cfg_i.width);
    h = cwlo_pkg::clamp_dim(cfg_i.height);
    col_c = in_data_i.frame_start ? '0 : col_q;
    row_c = in_data_i.frame_start ? '0 : row_q;
    in_band  = ({1'b0, row_c} >= cfg_i.first_row) && ({1'b0, row_c} < cfg_i.end_row);
    left     = {1'b0, col_c} < (w >> 1);
    last_col = {1'b0, col_c} >= (w - cwlo_pkg::REG_W'(1));
    last_row = {1'b0, row_c} >= (h - cwlo_pkg::REG_W'(1));
    col_d = last_col ? '0 : col_c + 1'b1;
    row_d = last_col ? (last_row ? '0 : row_c + 1'b1) : row_c;

    v = in_data_i.blue;
    m = in_data_i.blue;
    if (in_data_i.green > v) v = in_data_i.green;
    if (in_data_i.red > v)   v = in_data_i.red;
    if (in_data_i.green < m) m = in_data_i.green;
    if (in_data_i.red < m)   m = in_data_i.red;
    d = v - m;
    // The blue-max numerator reaches five times the spread, so it needs 12 bits.
    if (v == in_data_i.red)
      num = $signed({4'b0, in_data_i.green}) - $signed({4'b0, in_data_i.blue});
    else if (v == in_data_i.green)
      num = $signed({4'b0, in_data_i.blue}) - $signed({4'b0, in_data_i.red})
            + $signed({3'b0, d, 1'b0});
    else
      num = $signed({4'b0, in_data_i.red}) - $signed({4'b0, in_data_i.green})
            + $signed({2'b0, d, 2'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v_val_q <= v;
      s1_d_q     <= d;
      s1_num_q   <= num;
      s1_sdiv_q  <= sdiv_tab[v];
      s1_hdiv_q  <= hdiv_tab[d];
      s1_rpos_q  <= in_band && left;
      s1_gpos_q  <= in_band && !left;
      s1_last_q  <= last_col && last_row;
      s1_clr_q   <= in_data_i.frame_start;
      s2_ev_q    <= s2_ev_d;
    end
  end

  always_comb begin
    sat_p   = 28'(s1_d_q) * 28'(s1_sdiv_q);
    sat     = 16'((sat_p + 28'd2048) >> 12);
    hue_t   = 30'(s1_num_q) * $signed({12'b0, s1_hdiv_q}) + 30'sd2048;
    hue_raw = hue_t[29:12];
    hue     = (hue_raw < 0) ? hue_raw + 18'sd180 : hue_raw;
    is_red  = (hue <= 18'sd10 || (hue >= 18'sd170 && hue <= 18'sd180))
              && sat >= 16'd70 && s1_v_val_q >= 8'd50;
    is_green = (hue >= 18'sd40 && hue <= 18'sd90)
               && sat >= 16'd50 && s1_v_val_q >= 8'd50;
    s2_ev_d.clr       = s1_clr_q;
    s2_ev_d.red_hit   = s1_rpos_q && is_red;
    s2_ev_d.green_hit = s1_gpos_q && is_green;
    s2_ev_d.last      = s1_last_q;
  end

endmodule

>>> src/cwlo_queue.sv
// Small event queue between the classifying front and the counting back.
// Depends on cwlo_pkg for the event type and depth.
`timescale 1ns / 1ps
module cwlo_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cwlo_pkg::event_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cwlo_pkg::event_t data_o
);

  cwlo_pkg::event_t           mem_q [cwlo_pkg::QDEPTH];
  logic [cwlo_pkg::QPTR_W-1:0] wp_q, rp_q;
  logic [cwlo_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (cwlo_pkg::QPTR_W+1)'(cwlo_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (cwlo_pkg::QPTR_W+1)'(push_i) - (cwlo_pkg::QPTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

>>> src/cwlo_back.sv
// Back part: saturating totals and the iterative lane offset division.
// Depends on cwlo_pkg; pops events from the queue and drives the result.
`timescale 1ns / 1ps
module cwlo_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwlo_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  input  cwlo_pkg::event_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cwlo_pkg::result_t out_data_o,
  output logic [2:0]        state_o
);

  localparam int unsigned DW = 45;
  localparam logic [cwlo_pkg::CNT_W-1:0] CMAX = '1;

  logic [2:0]                 st_q, st_d;
  logic [cwlo_pkg::CNT_W-1:0] red_q, green_q, red_d, green_d, rb, gb;
  logic [cwlo_pkg::CNT_W-1:0] rres_q, gres_q;
  logic                       neg_q;
  logic [cwlo_pkg::CNT_W-1:0] mag_q;
  logic [25:0]                den_q;
  logic [DW-1:0]              rem_q, divs;
  logic [16:0]                quo_q;
  logic [4:0]                 k_q;
  logic                       sat_q;
  logic                       out_v_q;
  cwlo_pkg::result_t          out_q;
  logic signed [cwlo_pkg::OFS_W-1:0] ofs;
  logic [cwlo_pkg::REG_W-1:0] w, h;
  logic [DW-1:0]              nume;

  assign q_pop_o     = (st_q == cwlo_pkg::ST_IDLE) && !q_empty_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign state_o     = st_q;

  always_comb begin
    w    = cwlo_pkg::clamp_dim(cfg_i.width);
    h    = cwlo_pkg::clamp_dim(cfg_i.height);
    rb   = q_data_i.clr ? '0 : red_q;
    gb   = q_data_i.clr ? '0 : green_q;
    red_d   = (q_data_i.red_hit && rb != CMAX) ? rb + 1'b1 : rb;
    green_d = (q_data_i.green_hit && gb != CMAX) ? gb + 1'b1 : gb;
    nume = {4'b0, mag_q, 17'b0} + DW'(den_q);
    divs = DW'({den_q, 1'b0}) << k_q;
    if (neg_q) ofs = (sat_q || quo_q > 17'd32768) ? 16'sh8000 : -$signed(quo_q[15:0]);
    else       ofs = (sat_q || quo_q > 17'd32767) ? 16'sh7fff : $signed(quo_q[15:0]);
    st_d = st_q;
    case (st_q)
      cwlo_pkg::ST_IDLE: if (q_pop_o && q_data_i.last) st_d = cwlo_pkg::ST_MUL;
      cwlo_pkg::ST_MUL:  st_d = cwlo_pkg::ST_PREP;
      cwlo_pkg::ST_PREP: st_d = cwlo_pkg::ST_DIV;
      cwlo_pkg::ST_DIV:  if (k_q == 5'd0) st_d = cwlo_pkg::ST_DONE;
      cwlo_pkg::ST_DONE: if (!out_v_q || out_ready_i) st_d = cwlo_pkg::ST_IDLE;
      default:           st_d = cwlo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= cwlo_pkg::ST_IDLE;
      red_q   <= '0;
      green_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (q_pop_o) begin
        red_q   <= q_data_i.last ? '0 : red_d;
        green_q <= q_data_i.last ? '0 : green_d;
      end
      if (st_q == cwlo_pkg::ST_DONE && (!out_v_q || out_ready_i)) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      cwlo_pkg::ST_IDLE: begin
        if (q_pop_o && q_data_i.last) begin
          rres_q <= red_d;
          gres_q <= green_d;
          neg_q  <= red_d > green_d;
          mag_q  <= (red_d > green_d) ? red_d - green_d : green_d - red_d;
        end
      end
      cwlo_pkg::ST_MUL: den_q <= 26'(w) * 26'(h) + 26'd4;
      cwlo_pkg::ST_PREP: begin
        // Quotient of 2^17 or more always saturates.
        rem_q <= nume;
        sat_q <= nume >= (DW'(den_q) << 18);
        quo_q <= '0;
        k_q   <= 5'd16;
      end
      cwlo_pkg::ST_DIV: begin
        if (rem_q >= divs) begin
          rem_q      <= rem_q - divs;
          quo_q[k_q] <= 1'b1;
        end
        k_q <= k_q - 5'd1;
      end
      cwlo_pkg::ST_DONE: begin
        if (!out_v_q || out_ready_i) begin
          out_q.red_count   <= rres_q;
          out_q.green_count <= gres_q;
          out_q.wall_offset <= ofs;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/color_wall_lane_offset_core.sv
// Red/green wall pixel counter: takes one BGR pixel per ready cycle in raster order,
// classifies it by hue, saturation and value, counts red pixels in the left
// half and green pixels in the right half of the row band, and after the
// last pixel of a frame returns both counts with a saturated Q0.16 lane
// offset. Pixels are accepted at one per clock unless a full queue stalls the
// front; each passes a two-stage classifier into a four-entry event queue.
// The frame result is valid after its last pixel leaves the queue and the back
// has run a multiply, a setup step, a 17-step restoring divider and a load;
// pixels of the next frame keep entering until the queue fills meanwhile.
`timescale 1ns / 1ps
`include "color_wall_lane_offset_core_macros.svh"
module color_wall_lane_offset_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [cwlo_pkg::REG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cwlo_pkg::pixel_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cwlo_pkg::result_t          out_data_o
);

  cwlo_pkg::cfg_t   cfg_q;
  cwlo_pkg::event_t push_ev, pop_ev;
  logic             q_push, q_full;
  logic [2:0]       back_state;
  logic             q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= 13'd640;
      cfg_q.height    <= 13'd480;
      cfg_q.first_row <= 13'd192;
      cfg_q.end_row   <= 13'd432;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cwlo_pkg::REG_WIDTH:  cfg_q.width     <= cfg_data_i;
        cwlo_pkg::REG_HEIGHT: cfg_q.height    <= cfg_data_i;
        cwlo_pkg::REG_FIRST:  cfg_q.first_row <= cfg_data_i;
        cwlo_pkg::REG_END:    cfg_q.end_row   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cwlo_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_ready_o, .in_data_i,
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(push_ev)
  );

  cwlo_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(push_ev), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(pop_ev)
  );

  cwlo_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_empty_i(q_empty), .q_data_i(pop_ev),
    .q_pop_o(q_pop), .out_valid_o, .out_ready_i, .out_data_o,
    .state_o(back_state)
  );

  `CWLO_ASSERT_IMP(a_no_overflow, q_push, !q_full, "push into full queue")
  `CWLO_ASSERT_IMP(a_pop_idle, q_pop, back_state == cwlo_pkg::ST_IDLE && !q_empty, "bad pop")
  `CWLO_ASSERT(a_result_src, !$rose(out_valid_o) || $past(back_state == cwlo_pkg::ST_DONE), "result without divide")

endmodule

>>> tb/tb.sv
// Testbench for the red/green wall counter: streams BGR pixels through the
// request channel, predicts each frame result and checks every returned one.
// Depends on cwlo_pkg and color_wall_lane_offset_core only.
`timescale 1ns / 1ps
module tb;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [1:0]                 cfg_index_i = cwlo_pkg::REG_WIDTH;
  logic [cwlo_pkg::REG_W-1:0] cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  cwlo_pkg::pixel_t           in_data_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  cwlo_pkg::result_t          out_data_o;

  color_wall_lane_offset_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Register copies and frame state of the predictor.
  int unsigned width_reg = 640, height_reg = 480, first_reg = 192, end_reg = 432;
  int unsigned col_pos = 0, row_pos = 0, red_sum = 0, green_sum = 0;

  cwlo_pkg::pixel_t  pending_pixels[$];
  cwlo_pkg::result_t frame_results[$];
  int      errors = 0;
  int      accepted = 0;
  bit      req_taken = 0;
  bit      hold_sender = 0;
  bit      pressure_done = 0;
  int      burst_left = 0, gap_left = 0;
  int      ready_cycle = 0;

  function automatic int unsigned clamp_size(int unsigned v);
    if (v < 2) return 2;
    if (v > cwlo_pkg::MAX_DIMENSION) return cwlo_pkg::MAX_DIMENSION;
    return v;
  endfunction

  function automatic void classify_pixel(input int b, input int g, input int r,
                                         output bit is_red, output bit is_green);
    int     v, m, d, sdiv, hdiv, sat;
    longint num, t, hue;
    v = b; m = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < m) m = g;
    if (r < m) m = r;
    d = v - m;
    sdiv = (v != 0) ? (2 * 1044480 + v) / (2 * v) : 0;
    hdiv = (d != 0) ? (2 * 122880 + d) / (2 * d) : 0;
    sat = (d * sdiv + 2048) >>> 12;
    if (v == r) num = g - b;
    else if (v == g) num = b - r + 2 * d;
    else num = r - g + 4 * d;
    t = num * hdiv + 2048;
    if (t >= 0) hue = t / 4096;
    else hue = -((-t + 4095) / 4096);
    if (hue < 0) hue += 180;
    is_red = (hue <= 10 || (hue >= 170 && hue <= 180)) && sat >= 70 && v >= 50;
    is_green = (hue >= 40 && hue <= 90) && sat >= 50 && v >= 50;
  endfunction

  function automatic logic [cwlo_pkg::OFS_W-1:0] offset_of(int unsigned w, int unsigned h);
    longint diff, mag, den, q, s;
    diff = longint'(green_sum) - longint'(red_sum);
    mag = (diff < 0 ? -diff : diff) * 65536;
    den = longint'(w) * longint'(h) + 4;
    q = (2 * mag + den) / (2 * den);
    if (diff < 0) s = (q > 32768) ? -32768 : -q;
    else s = (q > 32767) ? 32767 : q;
    return s[cwlo_pkg::OFS_W-1:0];
  endfunction

  task automatic count_pixel(input cwlo_pkg::pixel_t px);
    int unsigned       w, h;
    bit                is_red, is_green;
    cwlo_pkg::result_t res;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    if (px.frame_start) begin
      col_pos = 0; row_pos = 0; red_sum = 0; green_sum = 0;
    end
    classify_pixel(px.blue, px.green, px.red, is_red, is_green);
    if (row_pos >= first_reg && row_pos < end_reg) begin
      if (col_pos < w / 2) begin
        if (is_red && red_sum < 24'hFFFFFF) red_sum++;
      end else if (is_green && green_sum < 24'hFFFFFF) begin
        green_sum++;
      end
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (row_pos >= h - 1) begin
        res.red_count = red_sum[cwlo_pkg::CNT_W-1:0];
        res.green_count = green_sum[cwlo_pkg::CNT_W-1:0];
        res.wall_offset = offset_of(w, h);
        frame_results.push_back(res);
        row_pos = 0; red_sum = 0; green_sum = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  // Accepted requests feed the predictor; returned results are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      req_taken = 1;
      count_pixel(in_data_i);
      accepted++;
      // Pause once a frame result is outstanding, so the sender waits for it.
      if (accepted >= 600 && !pressure_done && frame_results.size() > 0) begin
        hold_sender = 1;
        pressure_done = 1;
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results.size() == 0) begin
        $display("%0t: result with none expected: %h", $realtime, out_data_o);
        errors++;
      end else begin
        cwlo_pkg::result_t want;
        want = frame_results.pop_front();
        if (out_data_o.red_count !== want.red_count) begin
          $display("%0t: red_count expected %0d actual %0d", $realtime,
                   want.red_count, out_data_o.red_count);
          errors++;
        end
        if (out_data_o.green_count !== want.green_count) begin
          $display("%0t: green_count expected %0d actual %0d", $realtime,
                   want.green_count, out_data_o.green_count);
          errors++;
        end
        if (out_data_o.wall_offset !== want.wall_offset) begin
          $display("%0t: wall_offset expected %0d actual %0d", $realtime,
                   $signed(want.wall_offset), $signed(out_data_o.wall_offset));
          errors++;
        end
      end
    end
  end

  // Sender in bursts with gaps; receiver cycles through its own stall patterns.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !req_taken)) begin
        req_taken = 0;
        if (hold_sender && frame_results.size() == 0) hold_sender = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end
        if (!hold_sender && gap_left == 0 && pending_pixels.size() > 0) begin
          in_data_i <= pending_pixels.pop_front();
          in_valid_i <= 1'b1;
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
      ready_cycle++;
      case ((ready_cycle / 256) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= (ready_cycle % 8 == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[cwlo_pkg::REG_W-1:0];
    case (idx)
      cwlo_pkg::REG_WIDTH:  width_reg = value & 13'h1FFF;
      cwlo_pkg::REG_HEIGHT: height_reg = value & 13'h1FFF;
      cwlo_pkg::REG_FIRST:  first_reg = value & 13'h1FFF;
      default:              end_reg = value & 13'h1FFF;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input int unsigned first, input int unsigned last);
    write_reg(cwlo_pkg::REG_WIDTH, w);
    write_reg(cwlo_pkg::REG_HEIGHT, h);
    write_reg(cwlo_pkg::REG_FIRST, first);
    write_reg(cwlo_pkg::REG_END, last);
  endtask

  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && !in_valid_i && frame_results.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_pixel(input int b, input int g, input int r, input bit fs);
    cwlo_pkg::pixel_t px;
    px.blue = 8'(b); px.green = 8'(g); px.red = 8'(r); px.frame_start = fs;
    pending_pixels.push_back(px);
  endtask

  // Mostly red-ish and green-ish pixels so both counters move, plus noise.
  task automatic push_random_pixel(input bit fs);
    case ($urandom_range(0, 2))
      0: push_pixel($urandom_range(0, 80), $urandom_range(0, 80), $urandom_range(60, 255), fs);
      1: push_pixel($urandom_range(0, 90), $urandom_range(60, 255), $urandom_range(0, 90), fs);
      default: push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), fs);
    endcase
  endtask

  task automatic random_phase(input int unsigned w, input int unsigned h,
                              input int unsigned first, input int unsigned last,
                              input int count);
    int unsigned size;
    set_frame(w, h, first, last);
    size = clamp_size(w) * clamp_size(h);
    for (int i = 0; i < count; i++) begin
      if (i % size == 0) push_random_pixel(1'($urandom_range(0, 1)));
      else push_random_pixel($urandom_range(0, 39) == 0);
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 4x3 frames with every row in the band.
    set_frame(4, 3, 0, 3);
    push_pixel(0, 0, 0, 1);
    push_pixel(255, 255, 255, 0);
    push_pixel(255, 0, 0, 0);
    push_pixel(0, 255, 0, 0);
    push_pixel(0, 0, 255, 0);
    push_pixel(0, 43, 255, 0);
    push_pixel(0, 255, 255, 0);
    push_pixel(40, 0, 255, 0);
    push_pixel(255, 0, 255, 0);
    push_pixel(0, 40, 40, 0);
    push_pixel(255, 255, 0, 0);
    push_pixel(0, 255, 40, 0);
    push_pixel(40, 0, 255, 1);
    push_pixel(0, 0, 49, 0);
    push_pixel(200, 200, 255, 0);
    push_pixel(0, 255, 0, 0);
    push_pixel(0, 0, 255, 1);
    push_pixel(0, 0, 255, 0);
    push_pixel(0, 0, 255, 0);
    push_pixel(0, 0, 255, 0);
    push_pixel(0, 0, 255, 0);
    push_pixel(0, 0, 255, 0);
    push_pixel(170, 255, 85, 0);
    push_pixel(100, 150, 60, 0);
    wait_idle();

    random_phase(2, 2, 0, 2, 120);
    random_phase(0, 1, 0, 13'h1FFF, 120);
    random_phase(6, 5, 1, 4, 150);
    random_phase(8, 4, 3, 2, 120);
    random_phase(5, 7, 0, 0, 140);
    random_phase(3, 6, 2, 5, 150);
    random_phase(16, 8, 0, 8, 256);
    random_phase(4, 4, 13'h1FFF, 13'h1FFF, 48);
    // Widest frame after clamping, two rows tall; only its first pixels are sent.
    random_phase(13'h1FFF, 0, 0, 1, 24);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
